/* rtl/core/acol_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acol_pkg
// Shared types, codes and widths for the box collision table.
// ----------------------------------------------------------------------------
package acol_pkg;

  // table depth default
  localparam int ENTRIES_DEF = 64;

  // stream widths
  localparam int IN_TDATA_W  = 144;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 48;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 19;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_W = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_H = 1'b1;
  localparam logic [18:0] AREA_RESET = 19'h7FFFF;

  // operation codes
  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_ADD_WALL = 3'd1;
  localparam logic [2:0] OP_ADD_TRIG = 3'd2;
  localparam logic [2:0] OP_RECT     = 3'd3;
  localparam logic [2:0] OP_POINT    = 3'd4;
  localparam logic [2:0] OP_SLIDE    = 3'd5;

  // layer bits in the mask
  localparam int LAYER_WALL = 1;
  localparam int LAYER_TRIG = 3;

  // test box setup modes
  localparam logic [1:0] MODE_RECT    = 2'd0;
  localparam logic [1:0] MODE_POINT   = 2'd1;
  localparam logic [1:0] MODE_SLIDE_X = 2'd2;
  localparam logic [1:0] MODE_SLIDE_Y = 2'd3;

  // one input transaction
  typedef struct packed {
    logic [2:0]  op;
    logic [19:0] left;
    logic [19:0] top;
    logic [18:0] box_w;
    logic [18:0] box_h;
    logic [19:0] goal_x;
    logic [19:0] goal_y;
    logic [17:0] half_size;
    logic [3:0]  layer_select;
  } item_t;

  // one result, status in the lowest bit
  typedef struct packed {
    logic [19:0] end_y;
    logic [19:0] end_x;
    logic        hit;
    logic [5:0]  entry_index;
    logic        status;
  } result_t;

  // stored box, edges precomputed
  typedef struct packed {
    logic [19:0] left;
    logic [20:0] right;
    logic [19:0] top;
    logic [20:0] bottom;
    logic        trig;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       clear_tab;
    logic       add;
    logic       setup;
    logic [1:0] mode;
    logic       scan;
    logic       commit_x;
    logic       commit_y;
    logic       finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       scan_done;
    logic       out_free;
  } stat_t;

  // sign extension of a 20 bit coordinate
  function automatic logic signed [21:0] sx22(input logic [19:0] v);
    sx22 = $signed({{2{v[19]}}, v});
  endfunction

  // sign extension of a 21 bit edge
  function automatic logic signed [21:0] sx22w(input logic [20:0] v);
    sx22w = $signed({v[20], v});
  endfunction

endpackage

/* rtl/core/acol_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acol_ctrl
// Sequencer for the collision table: decodes an operation and steps the
// datapath through clear, add, scan, slide commit and result hand-off.
// ----------------------------------------------------------------------------
module acol_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  acol_pkg::stat_t stat,
  output acol_pkg::cmd_t  cmd
);
  import acol_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_COMMIT  = 3'd3;
  localparam logic [2:0] S_SETUP_Y = 3'd4;
  localparam logic [2:0] S_FINISH  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       phase;
  logic       phase_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          OP_CLEAR: begin
            cmd.clear_tab = 1'b1;
            state_next    = S_FINISH;
          end
          OP_ADD_WALL, OP_ADD_TRIG: begin
            cmd.add    = 1'b1;
            state_next = S_FINISH;
          end
          OP_RECT: begin
            cmd.setup  = 1'b1;
            cmd.mode   = MODE_RECT;
            state_next = S_SCAN;
          end
          OP_POINT: begin
            cmd.setup  = 1'b1;
            cmd.mode   = MODE_POINT;
            state_next = S_SCAN;
          end
          OP_SLIDE: begin
            cmd.setup  = 1'b1;
            cmd.mode   = MODE_SLIDE_X;
            phase_next = 1'b0;
            state_next = S_SCAN;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = (stat.op == OP_SLIDE) ? S_COMMIT : S_FINISH;
        end
      end
      S_COMMIT: begin
        if (!phase) begin
          cmd.commit_x = 1'b1;
          state_next   = S_SETUP_Y;
        end else begin
          cmd.commit_y = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_SETUP_Y: begin
        cmd.setup  = 1'b1;
        cmd.mode   = MODE_SLIDE_Y;
        phase_next = 1'b1;
        state_next = S_SCAN;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/acol_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acol_dp
// Datapath for the collision table: box memory, area registers, test box
// bounds, one-entry-per-cycle overlap scan and the result register.
// ----------------------------------------------------------------------------
module acol_dp #(
  parameter int ENTRIES = acol_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [acol_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acol_pkg::CFG_DATA_W-1:0] cfg_data,
  input  acol_pkg::item_t                item,
  input  acol_pkg::cmd_t                 cmd,
  output acol_pkg::stat_t                stat,
  input  logic                           out_ready,
  output logic                           out_valid,
  output acol_pkg::result_t              out_data
);
  import acol_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  // configuration and table fill
  logic [18:0]      area_w;
  logic [18:0]      area_h;
  logic [CNT_W-1:0] count;

  // latched item and slide state
  item_t       item_q;
  logic [19:0] cur_x;
  logic [19:0] cur_y;
  logic        slide_hit;
  logic        add_full;
  logic [5:0]  add_index;

  // test box
  logic signed [21:0] lo_x, hi_x, lo_y, hi_y;
  logic [3:0]         scan_mask;

  // scan
  logic [CNT_W-1:0] rd_addr;
  logic             rd_vld;
  logic             rd_en;
  logic             scan_hit;
  entry_t           rd_data;
  entry_t           mem [ENTRIES];
  entry_t           wr_word;
  logic             full;

  // bounds set-up
  logic [19:0]        cx, cy;
  logic [18:0]        ax, ay, bx, by;
  logic [3:0]         mask_sel;
  logic signed [21:0] lo_x_next, hi_x_next, lo_y_next, hi_y_next;

  // evaluation
  logic        area_fail;
  logic        pass_hit;
  logic        layer_ok;
  logic        overlap;
  logic [31:0] count_ext;
  logic        is_test;

  assign full  = (count >= FULL_CNT);
  assign rd_en = cmd.scan && (rd_addr < count);

  // centre or corner and extents per mode
  always_comb begin
    cx       = item_q.left;
    cy       = item_q.top;
    ax       = '0;
    ay       = '0;
    bx       = item_q.box_w;
    by       = item_q.box_h;
    mask_sel = item_q.layer_select;
    case (cmd.mode)
      MODE_RECT: begin
        cx = item_q.left;
        cy = item_q.top;
      end
      MODE_POINT: begin
        ax = {1'b0, item_q.half_size};
        ay = {1'b0, item_q.half_size};
        bx = {1'b0, item_q.half_size};
        by = {1'b0, item_q.half_size};
      end
      MODE_SLIDE_X: begin
        cx       = item_q.goal_x;
        cy       = cur_y;
        ax       = {1'b0, item_q.half_size};
        ay       = {1'b0, item_q.half_size};
        bx       = {1'b0, item_q.half_size};
        by       = {1'b0, item_q.half_size};
        mask_sel = 4'(1 << LAYER_WALL);
      end
      MODE_SLIDE_Y: begin
        cx       = cur_x;
        cy       = item_q.goal_y;
        ax       = {1'b0, item_q.half_size};
        ay       = {1'b0, item_q.half_size};
        bx       = {1'b0, item_q.half_size};
        by       = {1'b0, item_q.half_size};
        mask_sel = 4'(1 << LAYER_WALL);
      end
      default: begin
        cx = item_q.left;
      end
    endcase
  end

  assign lo_x_next = sx22(cx) - $signed({3'b000, ax});
  assign hi_x_next = sx22(cx) + $signed({3'b000, bx});
  assign lo_y_next = sx22(cy) - $signed({3'b000, ay});
  assign hi_y_next = sx22(cy) + $signed({3'b000, by});

  // new entry with right and bottom edges
  assign wr_word.left   = item_q.left;
  assign wr_word.right  = 21'($signed({item_q.left[19], item_q.left}) +
                              $signed({2'b00, item_q.box_w}));
  assign wr_word.top    = item_q.top;
  assign wr_word.bottom = 21'($signed({item_q.top[19], item_q.top}) +
                              $signed({2'b00, item_q.box_h}));
  assign wr_word.trig   = (item_q.op == OP_ADD_TRIG);

  // area check on the registered test box
  assign area_fail = lo_x[21] || lo_y[21] ||
                     (hi_x > $signed({3'b000, area_w})) ||
                     (hi_y > $signed({3'b000, area_h}));
  assign pass_hit  = scan_hit || area_fail;

  // overlap of the entry read last cycle
  assign layer_ok = rd_data.trig ? scan_mask[LAYER_TRIG] : scan_mask[LAYER_WALL];
  assign overlap  = (lo_x < sx22w(rd_data.right)) && (hi_x > sx22(rd_data.left)) &&
                    (lo_y < sx22w(rd_data.bottom)) && (hi_y > sx22(rd_data.top));

  assign count_ext = 32'(count);
  assign is_test   = (item_q.op == OP_RECT) || (item_q.op == OP_POINT);

  // box memory
  always_ff @(posedge clk) begin
    if (cmd.add && !full) begin
      mem[count[IDX_W-1:0]] <= wr_word;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr[IDX_W-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      area_w    <= AREA_RESET;
      area_h    <= AREA_RESET;
      count     <= '0;
      rd_addr   <= '0;
      rd_vld    <= 1'b0;
      scan_hit  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_AREA_W: area_w <= cfg_data;
          REG_AREA_H: area_h <= cfg_data;
          default: begin
          end
        endcase
      end
      // table fill
      if (cmd.clear_tab) begin
        count <= '0;
      end else if (cmd.add && !full) begin
        count <= count + 1'b1;
      end
      // scan walk
      if (cmd.setup) begin
        rd_addr  <= '0;
        scan_hit <= 1'b0;
      end else begin
        if (rd_en) begin
          rd_addr <= rd_addr + 1'b1;
        end
        if (rd_vld && layer_ok && overlap) begin
          scan_hit <= 1'b1;
        end
      end
      rd_vld <= rd_en;
      // result register
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q    <= item;
      cur_x     <= item.left;
      cur_y     <= item.top;
      slide_hit <= 1'b0;
      add_full  <= 1'b0;
      add_index <= '0;
    end
    if (cmd.add) begin
      if (full) begin
        add_full <= 1'b1;
      end else begin
        add_index <= count_ext[5:0];
      end
    end
    if (cmd.setup) begin
      lo_x      <= lo_x_next;
      hi_x      <= hi_x_next;
      lo_y      <= lo_y_next;
      hi_y      <= hi_y_next;
      scan_mask <= mask_sel;
    end
    if (cmd.commit_x) begin
      if (pass_hit) begin
        slide_hit <= 1'b1;
      end else begin
        cur_x <= item_q.goal_x;
      end
    end
    if (cmd.commit_y) begin
      if (pass_hit) begin
        slide_hit <= 1'b1;
      end else begin
        cur_y <= item_q.goal_y;
      end
    end
    if (cmd.finish) begin
      out_data.status      <= add_full;
      out_data.entry_index <= add_index;
      out_data.hit         <= is_test ? pass_hit :
                              ((item_q.op == OP_SLIDE) ? slide_hit : 1'b0);
      out_data.end_x       <= (item_q.op == OP_SLIDE) ? cur_x : '0;
      out_data.end_y       <= (item_q.op == OP_SLIDE) ? cur_y : '0;
    end
  end

  // status to the sequencer
  assign stat.op        = item_q.op;
  assign stat.scan_done = !rd_en && !rd_vld && (rd_addr >= count);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

/* rtl/core/aabb_collision_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_collision_table_top
// Box collision table with layer mask: add, clear, rectangle and point
// tests, and slide-move resolve, on signed Q15.4 coordinates.
// ----------------------------------------------------------------------------
// One operation is worked on at a time; every accepted transaction gives
// exactly one result. Clear and add do not scan. A rectangle or point
// test scans the stored boxes once and a slide move scans them twice (x,
// then y); the scan reads the box memory through its single read port,
// one entry per cycle. The next transaction is accepted while a finished
// result still waits in the output register. The table needs no clearing
// pass after reset.
module aabb_collision_table_top #(
  parameter int ENTRIES = acol_pkg::ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // left[19:0], top[39:20], box_w[58:40], box_h[77:59], goal_x[97:78],
  // goal_y[117:98], half_size[135:118], layer_select[139:136], zero pad
  input  logic [acol_pkg::IN_TDATA_W-1:0]  s_tdata,
  // op[2:0]
  input  logic [acol_pkg::IN_TUSER_W-1:0]  s_tuser,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // status[0], entry_index[6:1], hit[7], end_x[27:8], end_y[47:28]
  output logic [acol_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_wr_en,
  input  logic [acol_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [acol_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import acol_pkg::*;

  item_t   item;
  cmd_t    cmd;
  stat_t   stat;
  result_t res;

  // unpack the input transaction
  assign item.op           = s_tuser[2:0];
  assign item.left         = s_tdata[19:0];
  assign item.top          = s_tdata[39:20];
  assign item.box_w        = s_tdata[58:40];
  assign item.box_h        = s_tdata[77:59];
  assign item.goal_x       = s_tdata[97:78];
  assign item.goal_y       = s_tdata[117:98];
  assign item.half_size    = s_tdata[135:118];
  assign item.layer_select = s_tdata[139:136];

  acol_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  acol_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (res)
  );

  // pack the result
  assign m_tdata = res;

endmodule

/* rtl/core/acol_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acol_checker
// Port-level checks for the collision table, bound to the top level.
// ----------------------------------------------------------------------------
module acol_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [acol_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import acol_pkg::*;

  // one operation in flight: input closes after an accepted transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an operation is in progress");

  // no result can rise in the cycle straight after acceptance
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    else $error("result appeared too early");

  // a failed add carries index zero
  a_full_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[6:1] == 6'd0))
    else $error("table full result with non-zero index");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind aabb_collision_table_top acol_checker u_acol_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* test/aabb_collision_table_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_collision_table_top_tb
// Self-checking bench for the box collision table. Directed transactions
// cover edges, layers and each operation. A table-fill run drives the table
// past its depth. Random traffic then runs under several area settings and
// idle patterns. A local model of the table predicts every result, and each
// result is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module aabb_collision_table_top_tb;
  import acol_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 2 * ENTRIES_DEF + 24;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [3:0] WALL_ONLY = 4'b0001 << LAYER_WALL;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // model of the table and area
  int     area_w_q = int'(AREA_RESET);
  int     area_h_q = int'(AREA_RESET);
  int     tab_count = 0;
  longint tab_left [ENTRIES_DEF];
  longint tab_top [ENTRIES_DEF];
  longint tab_w [ENTRIES_DEF];
  longint tab_h [ENTRIES_DEF];
  bit     tab_trig [ENTRIES_DEF];

  result_t pending [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  int n_fail = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_hits = 0;
  int n_full = 0;

  aabb_collision_table_top #(
    .ENTRIES (ENTRIES_DEF)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t ns: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // strict overlap against the area and every selected stored box
  function automatic bit box_blocked(input longint x, input longint y,
                                     input longint w, input longint h,
                                     input logic [3:0] mask);
    int layer;
    longint bx;
    longint by;
    if (x < 0 || x + w > longint'(area_w_q) || y < 0 || y + h > longint'(area_h_q))
      return 1'b1;
    for (int i = 0; i < tab_count; i++) begin
      layer = tab_trig[i] ? LAYER_TRIG : LAYER_WALL;
      if (!mask[layer])
        continue;
      bx = tab_left[i];
      by = tab_top[i];
      if (x < bx + tab_w[i] && x + w > bx && y < by + tab_h[i] && y + h > by)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit point_blocked(input longint x, input longint y,
                                       input longint r, input logic [3:0] mask);
    return box_blocked(x - r, y - r, 2 * r, 2 * r, mask);
  endfunction

  // advance the table model by one transaction and give its result
  function automatic result_t apply_item(input item_t it);
    result_t res;
    longint x;
    longint y;
    longint gx;
    longint gy;
    longint r;
    longint ex;
    longint ey;
    res = '0;
    x = longint'($signed(it.left));
    y = longint'($signed(it.top));
    gx = longint'($signed(it.goal_x));
    gy = longint'($signed(it.goal_y));
    r = longint'(it.half_size);
    case (it.op)
      OP_CLEAR: begin
        tab_count = 0;
      end
      OP_ADD_WALL, OP_ADD_TRIG: begin
        if (tab_count >= ENTRIES_DEF) begin
          res.status = 1'b1;
        end else begin
          tab_left[tab_count] = x;
          tab_top[tab_count] = y;
          tab_w[tab_count] = longint'(it.box_w);
          tab_h[tab_count] = longint'(it.box_h);
          tab_trig[tab_count] = (it.op == OP_ADD_TRIG);
          res.entry_index = tab_count[5:0];
          tab_count++;
        end
      end
      OP_RECT: begin
        res.hit = box_blocked(x, y, longint'(it.box_w), longint'(it.box_h),
                              it.layer_select);
      end
      OP_POINT: begin
        res.hit = point_blocked(x, y, r, it.layer_select);
      end
      OP_SLIDE: begin
        // x first at the current y, then y at the resulting x, walls only
        ex = x;
        ey = y;
        if (!point_blocked(gx, ey, r, WALL_ONLY))
          ex = gx;
        else
          res.hit = 1'b1;
        if (!point_blocked(ex, gy, r, WALL_ONLY))
          ey = gy;
        else
          res.hit = 1'b1;
        res.end_x = ex[19:0];
        res.end_y = ey[19:0];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic item_t mk(input logic [2:0] op, input int lx, input int ty,
                               input int w, input int h, input int gx,
                               input int gy, input int r, input logic [3:0] mask);
    item_t it;
    it.op = op;
    it.left = lx[19:0];
    it.top = ty[19:0];
    it.box_w = w[18:0];
    it.box_h = h[18:0];
    it.goal_x = gx[19:0];
    it.goal_y = gy[19:0];
    it.half_size = r[17:0];
    it.layer_select = mask;
    return it;
  endfunction

  function automatic logic [19:0] clamp20(input int v);
    int c;
    c = (v < -524288) ? -524288 : ((v > 524287) ? 524287 : v);
    return c[19:0];
  endfunction

  // mostly around the area, sometimes anywhere
  function automatic logic [19:0] pick_pos(input int span);
    int v;
    if ($urandom_range(0, 99) < 12) begin
      v = $urandom;
      return v[19:0];
    end
    v = int'($urandom_range(0, span + span / 4)) - span / 8;
    return clamp20(v);
  endfunction

  function automatic logic [19:0] pick_near(input logic [19:0] cur, input int span);
    int v;
    if ($urandom_range(0, 9) == 0)
      return pick_pos(span);
    v = int'($signed(cur)) + int'($urandom_range(0, span / 8 + 2)) - (span / 16 + 1);
    return clamp20(v);
  endfunction

  function automatic logic [18:0] pick_size(input int span);
    int v;
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      v = $urandom;
    else if (r < 20)
      v = 0;
    else
      v = $urandom_range(0, span / 6 + 1);
    return v[18:0];
  endfunction

  function automatic logic [17:0] pick_half(input int span);
    int v;
    if ($urandom_range(0, 99) < 10)
      v = $urandom;
    else
      v = $urandom_range(0, span / 16 + 1);
    return v[17:0];
  endfunction

  function automatic item_t random_item(input int span);
    item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)
      it.op = OP_CLEAR;
    else if (r < 20)
      it.op = OP_ADD_WALL;
    else if (r < 30)
      it.op = OP_ADD_TRIG;
    else if (r < 52)
      it.op = OP_RECT;
    else if (r < 74)
      it.op = OP_POINT;
    else if (r < 96)
      it.op = OP_SLIDE;
    else if (r < 98)
      it.op = OP_SPARE_A;
    else
      it.op = OP_SPARE_B;
    it.left = pick_pos(span);
    it.top = pick_pos(span);
    it.box_w = pick_size(span);
    it.box_h = pick_size(span);
    it.goal_x = pick_near(it.left, span);
    it.goal_y = pick_near(it.top, span);
    it.half_size = pick_half(span);
    it.layer_select = 4'($urandom_range(0, 15));
    return it;
  endfunction

  // present one transaction after an optional gap, predict on acceptance
  task automatic send_item(input item_t it);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.op;
    s_tdata <= {4'b0, it.layer_select, it.half_size, it.goal_y, it.goal_x,
                it.box_h, it.box_w, it.top, it.left};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    pending.push_back(apply_item(it));
    n_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0)
      @(posedge clk);
  endtask

  // both area registers on consecutive cycles, only while idle
  task automatic set_area(input int aw, input int ah);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_AREA_W;
    cfg_data <= aw[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_AREA_H;
    cfg_data <= ah[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    area_w_q = aw;
    area_h_q = ah;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      n_fail++;
      if (n_fail <= 40)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending.size() == 0) begin
      n_fail++;
      if (n_fail <= 40)
        $display("%0t ns: unexpected result, expected none, got %h", $time, got);
      return;
    end
    want = pending.pop_front();
    n_checked++;
    if (want.hit)
      n_hits++;
    if (want.status)
      n_full++;
    check_field("status", want.status, got.status);
    check_field("entry_index", want.entry_index, got.entry_index);
    check_field("hit", want.hit, got.hit);
    check_field("end_x", $signed(want.end_x), $signed(got.end_x));
    check_field("end_y", $signed(want.end_y), $signed(got.end_y));
  endtask

  // result side: check each output transaction, random back-pressure
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      check_result(m_tdata);
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // edges, layers, unused codes and every operation at the reset area
  task automatic test_basic_ops();
    send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 4'hF));
    send_item(mk(OP_RECT, 0, 0, 0, 0, 0, 0, 0, 4'hF));
    send_item(mk(OP_ADD_WALL, 100, 100, 50, 50, 0, 0, 0, 4'h0));
    send_item(mk(OP_ADD_TRIG, 300, 100, 50, 50, 0, 0, 0, 4'h0));
    send_item(mk(OP_RECT, 120, 120, 10, 10, 0, 0, 0, 4'b0010));
    send_item(mk(OP_RECT, 120, 120, 10, 10, 0, 0, 0, 4'b1000));
    // edges that only touch do not overlap
    send_item(mk(OP_RECT, 150, 100, 10, 10, 0, 0, 0, 4'hF));
    // mask bits 0 and 2 select nothing
    send_item(mk(OP_RECT, 310, 110, 5, 5, 0, 0, 0, 4'b0101));
    send_item(mk(OP_RECT, 310, 110, 5, 5, 0, 0, 0, 4'b1000));
    send_item(mk(OP_RECT, -1, 0, 5, 5, 0, 0, 0, 4'h0));
    send_item(mk(OP_RECT, 0, 0, 524287, 524287, 0, 0, 0, 4'h0));
    send_item(mk(OP_RECT, 1, 0, 524287, 0, 0, 0, 0, 4'h0));
    send_item(mk(OP_RECT, 524287, -524288, 524287, 524287, 0, 0, 0, 4'hF));
    send_item(mk(OP_POINT, 90, 125, 0, 0, 0, 0, 10, 4'b0010));
    send_item(mk(OP_POINT, 91, 125, 0, 0, 0, 0, 10, 4'b0010));
    send_item(mk(OP_POINT, 262143, 262143, 0, 0, 0, 0, 262143, 4'h0));
    // slide blocked on x, free on y
    send_item(mk(OP_SLIDE, 50, 125, 0, 0, 95, 200, 10, 4'hF));
    send_item(mk(OP_SLIDE, 50, 50, 0, 0, 60, 60, 5, 4'h0));
    // slide ignores triggers whatever the mask
    send_item(mk(OP_SLIDE, 290, 125, 0, 0, 320, 125, 5, 4'b1000));
    send_item(mk(OP_SLIDE, 0, 0, 0, 0, -524288, 524287, 0, 4'hF));
    send_item(mk(OP_SPARE_A, -1, -1, 524287, 524287, -1, -1, 262143, 4'hF));
    send_item(mk(OP_SPARE_B, -1, -1, 524287, 524287, -1, -1, 262143, 4'hF));
    send_item(mk(OP_ADD_WALL, -524288, 524287, 524287, 524287, 0, 0, 0, 4'h0));
    send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 4'h0));
    send_item(mk(OP_RECT, 120, 120, 10, 10, 0, 0, 0, 4'hF));
    wait_drained();
  endtask

  // fill past the depth, then work against a full table
  task automatic test_table_full();
    item_t it;
    send_idle_pct = 23;
    recv_stall_pct = 23;
    send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 4'h0));
    for (int i = 0; i < ENTRIES_DEF + 3; i++) begin
      it = random_item(4096);
      it.op = (i % 2 == 1) ? OP_ADD_TRIG : OP_ADD_WALL;
      send_item(it);
    end
    for (int i = 0; i < 6; i++) begin
      it = random_item(4096);
      it.op = (i % 3 == 0) ? OP_RECT : ((i % 3 == 1) ? OP_POINT : OP_SLIDE);
      send_item(it);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(input int aw, input int ah, input int span,
                                     input int count, input int sidle,
                                     input int rstall);
    set_area(aw, ah);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (count) send_item(random_item(span));
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_table_full();
    test_random_traffic(524287, 524287, 8192, 90, 0, 0);
    test_random_traffic(4000, 3000, 4000, 90, 75, 0);
    test_random_traffic(0, 0, 256, 40, 0, 75);
    test_random_traffic(524287, 1000, 1000, 90, 23, 23);
    test_random_traffic(1000, 524287, 1000, 80, 0, 0);
    test_random_traffic(2048, 2048, 2048, 90, 0, 75);
    test_random_traffic(65535, 300, 300, 80, 23, 23);
    test_random_traffic(524287, 524287, 524287, 80, 75, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d transactions over clear, add, rect, point and slide ops",
             n_sent);
    $display("checked %0d results: %0d hits, %0d adds on a full table",
             n_checked, n_hits, n_full);
    if (n_fail == 0 && pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_fail, pending.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
